### rtl/core/vcpt_pkg.sv
// vcpt_pkg: shared types, constants and frame builders for the valve command
// pulse transmitter; no dependencies, used by every module in rtl/core

package vcpt_pkg;

  // stream and config widths
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned IN_TUSER_W  = 2;
  localparam int unsigned OUT_TDATA_W = 8;
  localparam int unsigned CFG_ADDR_W  = 3;
  localparam int unsigned CFG_DATA_W  = 20;

  localparam int unsigned ZONE_W  = 6;
  localparam int unsigned MIN_W   = 8;
  localparam int unsigned PROG_W  = 3;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned PULSE_W = 16;
  localparam int unsigned RESET_W = 20;
  localparam int unsigned CNT_W   = 20;
  localparam int unsigned BIDX_W  = 7;

  localparam int unsigned QUEUE_DEPTH = 2;

  // frame geometry
  localparam int unsigned FRAME_BITS = 120;
  localparam logic [BIDX_W-1:0] ZONE_FRAME_BITS = 7'd120;
  localparam logic [BIDX_W-1:0] PROG_FRAME_BITS = 7'd56;

  localparam logic [119:0] ZONE_BASE = 120'hff_00_00_00_10_00_00_04_00_00_01_00_01_b8_3f;
  localparam logic [55:0]  PROG_BASE = 56'hff_40_03_96_09_bd_7f;

  // command limits and offsets
  localparam logic [ZONE_W-1:0] ZONE_MIN   = 6'd1;
  localparam logic [ZONE_W-1:0] ZONE_MAX   = 6'd48;
  localparam logic [ZONE_W-1:0] ZONE_SPLIT = 6'd12;
  localparam logic [MIN_W-1:0]  MIN_MAX    = 8'd240;
  localparam logic [PROG_W-1:0] PROG_MIN   = 3'd1;
  localparam logic [PROG_W-1:0] PROG_MAX   = 3'd4;
  localparam logic [6:0]        OFS_A      = 7'h17;
  localparam logic [6:0]        OFS_B      = 7'h23;
  localparam logic [6:0]        OFS_C      = 7'h2f;

  // kind codes on tuser
  localparam logic [IN_TUSER_W-1:0] KIND_TICK = 2'd0;
  localparam logic [IN_TUSER_W-1:0] KIND_ZONE = 2'd1;
  localparam logic [IN_TUSER_W-1:0] KIND_PROG = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_BAD_ZONE = 3'd1;
  localparam logic [STAT_W-1:0] ST_BAD_TIME = 3'd2;
  localparam logic [STAT_W-1:0] ST_BAD_PROG = 3'd3;
  localparam logic [STAT_W-1:0] ST_BUSY     = 3'd4;

  // config register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_SHORT   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_LONG    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_START   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_RST_HI  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_RST_LO  = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_INVERT  = 3'd5;

  localparam logic [PULSE_W-1:0] SHORT_RST   = 16'd208;
  localparam logic [PULSE_W-1:0] LONG_RST    = 16'd1875;
  localparam logic [PULSE_W-1:0] START_RST   = 16'd900;
  localparam logic [RESET_W-1:0] RST_HI_RST  = 20'd325000;
  localparam logic [RESET_W-1:0] RST_LO_RST  = 20'd65000;

  typedef enum logic [2:0] {
    OP_TICK,
    OP_ZONE,
    OP_PROG,
    OP_BAD,
    OP_NONE
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [STAT_W-1:0] err;
    logic [ZONE_W-1:0] zone;
    logic [MIN_W-1:0]  run_minutes;
    logic [PROG_W-1:0] program_number;
  } entry_t;

  // bit positions count from the msb of byte 0, value goes in lsb first
  function automatic logic [FRAME_BITS-1:0] put_field(input logic [FRAME_BITS-1:0] f,
                                                      input int unsigned pos,
                                                      input logic [6:0] val,
                                                      input int unsigned len);
    logic [FRAME_BITS-1:0] r;
    r = f;
    for (int unsigned k = 0; k < 7; k++) begin
      if (k < len) begin
        r[FRAME_BITS-1-pos-k] = val[k];
      end
    end
    return r;
  endfunction

  function automatic logic [FRAME_BITS-1:0] zone_frame(input logic [ZONE_W-1:0] zone,
                                                       input logic [MIN_W-1:0] mins);
    logic [FRAME_BITS-1:0] f;
    logic [6:0]            z7;
    logic [6:0]            lo;
    logic [6:0]            hi;
    logic [6:0]            grp;
    logic [6:0]            zm1;
    z7  = {1'b0, zone};
    lo  = {3'b000, mins[3:0]};
    hi  = {3'b000, mins[7:4]};
    grp = (zone > ZONE_SPLIT) ? 7'd1 : 7'd2;
    zm1 = z7 - 7'd1;
    f = ZONE_BASE;
    f = put_field(f, 9, grp, 2);
    f = put_field(f, 23, z7 + OFS_A, 7);
    f = put_field(f, 36, z7 + OFS_A, 7);
    f = put_field(f, 49, z7 + OFS_B, 7);
    f = put_field(f, 62, z7 + OFS_B, 7);
    f = put_field(f, 75, z7 + OFS_C, 7);
    f = put_field(f, 88, z7 + OFS_C, 7);
    f = put_field(f, 31, lo, 4);
    f = put_field(f, 44, hi, 4);
    f = put_field(f, 57, lo, 4);
    f = put_field(f, 70, hi, 4);
    f = put_field(f, 83, lo, 4);
    f = put_field(f, 96, hi, 4);
    f = put_field(f, 109, {3'b000, zm1[3:0]}, 4);
    return f;
  endfunction

  function automatic logic [FRAME_BITS-1:0] prog_frame(input logic [PROG_W-1:0] prog);
    logic [FRAME_BITS-1:0] f;
    logic [PROG_W-1:0]     pm1;
    pm1 = prog - 3'd1;
    f = '0;
    f[FRAME_BITS-1 -: 56] = PROG_BASE;
    f = put_field(f, 31, {5'b00000, pm1[1:0]}, 2);
    return f;
  endfunction

endpackage

### rtl/core/vcpt_front.sv
// vcpt_front: accepts input beats and classifies them into queue entries
// depends on vcpt_pkg

module vcpt_front (
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [vcpt_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  input  logic [vcpt_pkg::IN_TUSER_W-1:0]    s_axis_tuser_i,
  input  logic                               q_full_i,
  output logic                               q_push_o,
  output vcpt_pkg::entry_t                   q_entry_o
);

  logic [vcpt_pkg::ZONE_W-1:0] zone;
  logic [vcpt_pkg::MIN_W-1:0]  mins;
  logic [vcpt_pkg::PROG_W-1:0] prog;

  assign zone = s_axis_tdata_i[5:0];
  assign mins = s_axis_tdata_i[13:6];
  assign prog = s_axis_tdata_i[16:14];

  assign s_axis_tready_o = !q_full_i;
  assign q_push_o        = s_axis_tvalid_i && !q_full_i;

  always_comb begin
    q_entry_o.zone           = zone;
    q_entry_o.run_minutes    = mins;
    q_entry_o.program_number = prog;
    q_entry_o.err            = vcpt_pkg::ST_OK;
    q_entry_o.op             = vcpt_pkg::OP_NONE;
    case (s_axis_tuser_i)
      vcpt_pkg::KIND_TICK: begin
        q_entry_o.op = vcpt_pkg::OP_TICK;
      end
      vcpt_pkg::KIND_ZONE: begin
        if (zone < vcpt_pkg::ZONE_MIN || zone > vcpt_pkg::ZONE_MAX) begin
          q_entry_o.op  = vcpt_pkg::OP_BAD;
          q_entry_o.err = vcpt_pkg::ST_BAD_ZONE;
        end else if (mins > vcpt_pkg::MIN_MAX) begin
          q_entry_o.op  = vcpt_pkg::OP_BAD;
          q_entry_o.err = vcpt_pkg::ST_BAD_TIME;
        end else begin
          q_entry_o.op = vcpt_pkg::OP_ZONE;
        end
      end
      vcpt_pkg::KIND_PROG: begin
        if (prog < vcpt_pkg::PROG_MIN || prog > vcpt_pkg::PROG_MAX) begin
          q_entry_o.op  = vcpt_pkg::OP_BAD;
          q_entry_o.err = vcpt_pkg::ST_BAD_PROG;
        end else begin
          q_entry_o.op = vcpt_pkg::OP_PROG;
        end
      end
      default: begin
        q_entry_o.op = vcpt_pkg::OP_NONE;
      end
    endcase
  end

endmodule

### rtl/core/vcpt_fifo.sv
// vcpt_fifo: small queue of classified entries between front and back
// depends on vcpt_pkg

module vcpt_fifo #(
  parameter int unsigned Depth = vcpt_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  vcpt_pkg::entry_t entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output vcpt_pkg::entry_t entry_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

  vcpt_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  assign full_o  = (cnt_q == DepthCnt);
  assign empty_o = (cnt_q == '0);
  assign entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

### rtl/core/vcpt_back.sv
// vcpt_back: executes queued entries, holds the frame, line sequencer,
// config registers and the output register; depends on vcpt_pkg

module vcpt_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [vcpt_pkg::CFG_ADDR_W-1:0]     cfg_addr_i,
  input  logic [vcpt_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                                q_empty_i,
  input  vcpt_pkg::entry_t                    q_entry_i,
  output logic                                q_pop_o,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  output logic [vcpt_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o,
  output logic                                m_axis_tlast_o
);

  localparam logic [3:0] PH_IDLE    = 4'd0;
  localparam logic [3:0] PH_RST_H   = 4'd1;
  localparam logic [3:0] PH_RST_L   = 4'd2;
  localparam logic [3:0] PH_START_H = 4'd3;
  localparam logic [3:0] PH_START_L = 4'd4;
  localparam logic [3:0] PH_BIT_H   = 4'd5;
  localparam logic [3:0] PH_BIT_L   = 4'd6;

  localparam int unsigned CW = vcpt_pkg::CNT_W;
  localparam int unsigned BW = vcpt_pkg::BIDX_W;

  // config registers
  logic [vcpt_pkg::PULSE_W-1:0] short_q, long_q, start_q;
  logic [vcpt_pkg::RESET_W-1:0] rst_hi_q, rst_lo_q;
  logic                         invert_q;

  // sequencer state
  logic [vcpt_pkg::FRAME_BITS-1:0] frame_q, frame_d;
  logic [BW-1:0]                   fbits_q, fbits_d;
  logic [BW-1:0]                   bidx_q, bidx_d;
  logic                            extra_q, extra_d;
  logic [3:0]                      phase_q, phase_d;
  logic [CW-1:0]                   cnt_q, cnt_d;

  logic                            out_valid_q, out_valid_d;
  logic [vcpt_pkg::OUT_TDATA_W-1:0] out_data_q, out_data_d;
  logic                            out_last_q, out_last_d;

  logic                            busy;
  logic                            cur_bit;
  logic [BW-1:0]                   bit_pos;
  logic [CW-1:0]                   plen;
  logic [CW-1:0]                   cnt_inc;
  logic [vcpt_pkg::STAT_W-1:0]     status;
  logic                            done;
  logic                            level;

  function automatic logic [CW-1:0] at_least_one(input logic [CW-1:0] v);
    return (v == '0) ? CW'(1) : v;
  endfunction

  assign busy    = (phase_q != PH_IDLE);
  assign q_pop_o = !q_empty_i && (!out_valid_q || m_axis_tready_i);
  assign bit_pos = BW'(vcpt_pkg::FRAME_BITS - 1) - bidx_q;
  assign cnt_inc = cnt_q + 1'b1;

  always_comb begin
    if (bidx_q < fbits_q) begin
      cur_bit = frame_q[bit_pos];
    end else begin
      cur_bit = extra_q && (bidx_q == fbits_q);
    end
  end

  always_comb begin
    case (phase_q)
      PH_RST_H:   plen = at_least_one(rst_hi_q);
      PH_RST_L:   plen = at_least_one(rst_lo_q);
      PH_START_H: plen = at_least_one(CW'(start_q));
      PH_START_L: plen = at_least_one(CW'(short_q));
      PH_BIT_H:   plen = at_least_one(cur_bit ? CW'(long_q) : CW'(short_q));
      PH_BIT_L:   plen = at_least_one(cur_bit ? CW'(short_q) : CW'(long_q));
      default:    plen = CW'(1);
    endcase
  end

  always_comb begin
    frame_d = frame_q;
    fbits_d = fbits_q;
    bidx_d  = bidx_q;
    extra_d = extra_q;
    phase_d = phase_q;
    cnt_d   = cnt_q;
    status  = vcpt_pkg::ST_OK;
    done    = 1'b0;
    if (q_pop_o) begin
      case (q_entry_i.op)
        vcpt_pkg::OP_ZONE, vcpt_pkg::OP_PROG, vcpt_pkg::OP_BAD: begin
          if (busy) begin
            status = vcpt_pkg::ST_BUSY;
          end else if (q_entry_i.op == vcpt_pkg::OP_BAD) begin
            status = q_entry_i.err;
          end else begin
            if (q_entry_i.op == vcpt_pkg::OP_ZONE) begin
              frame_d = vcpt_pkg::zone_frame(q_entry_i.zone, q_entry_i.run_minutes);
              fbits_d = vcpt_pkg::ZONE_FRAME_BITS;
              extra_d = 1'b1;
            end else begin
              frame_d = vcpt_pkg::prog_frame(q_entry_i.program_number);
              fbits_d = vcpt_pkg::PROG_FRAME_BITS;
              extra_d = 1'b0;
            end
            bidx_d  = '0;
            phase_d = PH_RST_H;
            cnt_d   = '0;
          end
        end
        vcpt_pkg::OP_TICK: begin
          if (busy) begin
            if (cnt_inc >= plen) begin
              cnt_d = '0;
              case (phase_q)
                PH_RST_H:   phase_d = PH_RST_L;
                PH_RST_L:   phase_d = PH_START_H;
                PH_START_H: phase_d = PH_START_L;
                PH_START_L: phase_d = PH_BIT_H;
                PH_BIT_H:   phase_d = PH_BIT_L;
                PH_BIT_L: begin
                  // the extra one bit of zone frames counts as one more bit
                  if ({1'b0, bidx_q} >= ({1'b0, fbits_q} + {{BW{1'b0}}, extra_q})) begin
                    phase_d = PH_IDLE;
                    bidx_d  = '0;
                    done    = 1'b1;
                  end else begin
                    bidx_d  = bidx_q + 1'b1;
                    phase_d = PH_BIT_H;
                  end
                end
                default: phase_d = PH_IDLE;
              endcase
            end else begin
              cnt_d = cnt_inc;
            end
          end
        end
        default: begin
          status = vcpt_pkg::ST_OK;
        end
      endcase
    end
  end

  assign level = ((phase_d == PH_RST_H) || (phase_d == PH_START_H) ||
                  (phase_d == PH_BIT_H)) ^ invert_q;

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    if (q_pop_o) begin
      out_valid_d = 1'b1;
      out_data_d  = {3'b000, status, (phase_d != PH_IDLE), level};
      out_last_d  = done;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_q  <= vcpt_pkg::SHORT_RST;
      long_q   <= vcpt_pkg::LONG_RST;
      start_q  <= vcpt_pkg::START_RST;
      rst_hi_q <= vcpt_pkg::RST_HI_RST;
      rst_lo_q <= vcpt_pkg::RST_LO_RST;
      invert_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        vcpt_pkg::REG_SHORT:  short_q  <= cfg_wdata_i[vcpt_pkg::PULSE_W-1:0];
        vcpt_pkg::REG_LONG:   long_q   <= cfg_wdata_i[vcpt_pkg::PULSE_W-1:0];
        vcpt_pkg::REG_START:  start_q  <= cfg_wdata_i[vcpt_pkg::PULSE_W-1:0];
        vcpt_pkg::REG_RST_HI: rst_hi_q <= cfg_wdata_i[vcpt_pkg::RESET_W-1:0];
        vcpt_pkg::REG_RST_LO: rst_lo_q <= cfg_wdata_i[vcpt_pkg::RESET_W-1:0];
        vcpt_pkg::REG_INVERT: invert_q <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fbits_q     <= '0;
      bidx_q      <= '0;
      extra_q     <= 1'b0;
      phase_q     <= PH_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fbits_q     <= fbits_d;
      bidx_q      <= bidx_d;
      extra_q     <= extra_d;
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    frame_q    <= frame_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

### rtl/core/valve_command_pulse_transmitter.sv
// valve_command_pulse_transmitter: top level, front classifier, entry queue
// and back sequencer; depends on vcpt_pkg, vcpt_front, vcpt_fifo, vcpt_back

// Each input beat is a one-microsecond tick, a zone/program command or a spare
// kind and gives exactly one result beat. The block takes one beat per clock
// cycle while the queue is not full: the front classifies a beat in the cycle
// it is accepted, the back sequencer executes one queued entry per cycle while
// the output register is free or being read and registers its result there; a
// result goes through the queue and then the output register, and the sustained
// rate is one beat per cycle while the receiver keeps up. The queue between front
// and back (QueueDepth entries) and the output register let either side stall
// independently. Config writes are taken at any time but should only be made
// while no frame is on the line and no beat is in flight.

module valve_command_pulse_transmitter #(
  parameter int unsigned QueueDepth = vcpt_pkg::QUEUE_DEPTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // zone [5:0], run_minutes [13:6], program_number [16:14], zero [23:17]
  input  logic [vcpt_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i,
  // kind [1:0]
  input  logic [vcpt_pkg::IN_TUSER_W-1:0]   s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // line_level [0], busy_res [1], status [4:2], zero [7:5]
  output logic [vcpt_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o,
  // frame_done
  output logic                              m_axis_tlast_o,
  input  logic                              cfg_we_i,
  input  logic [vcpt_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [vcpt_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);

  logic             q_full;
  logic             q_empty;
  logic             q_push;
  logic             q_pop;
  vcpt_pkg::entry_t q_in;
  vcpt_pkg::entry_t q_out;

  vcpt_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_entry_o       (q_in)
  );

  vcpt_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .entry_o (q_out)
  );

  vcpt_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .q_empty_i       (q_empty),
    .q_entry_i       (q_out),
    .q_pop_o         (q_pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

### test/valve_command_pulse_transmitter_monitor.sv
// valve_command_pulse_transmitter_monitor: watches the command/tick stream, the
// result stream and the register port, predicts every result beat and compares
// it; depends on vcpt_pkg for codes, widths and register reset values

module valve_command_pulse_transmitter_monitor (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  input  logic                             s_axis_tready_i,
  // zone [5:0], run_minutes [13:6], program_number [16:14], zero [23:17]
  input  logic [vcpt_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  // kind [1:0]
  input  logic [vcpt_pkg::IN_TUSER_W-1:0]  s_axis_tuser_i,
  input  logic                             m_axis_tvalid_i,
  input  logic                             m_axis_tready_i,
  // line_level [0], busy_res [1], status [4:2], zero [7:5]
  input  logic [vcpt_pkg::OUT_TDATA_W-1:0] m_axis_tdata_i,
  input  logic                             m_axis_tlast_i,
  input  logic                             cfg_we_i,
  input  logic [vcpt_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [vcpt_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  output int                               fail_count_o,
  output int                               pending_o
);

  localparam logic [0:119] ZONE_PATTERN = 120'hff_00_00_00_10_00_00_04_00_00_01_00_01_b8_3f;
  localparam logic [0:55]  PROG_PATTERN = 56'hff_40_03_96_09_bd_7f;
  localparam logic [6:0]   ZONE_OFFSET_1 = 7'h17;
  localparam logic [6:0]   ZONE_OFFSET_2 = 7'h23;
  localparam logic [6:0]   ZONE_OFFSET_3 = 7'h2f;
  localparam int           ZONE_LAST     = 48;
  localparam int           ZONE_GROUP_1  = 12;
  localparam int           MINUTES_MAX   = 240;
  localparam int           PROG_LAST     = 4;

  typedef enum logic [2:0] {
    LN_IDLE,
    LN_RST_H,
    LN_RST_L,
    LN_START_H,
    LN_START_L,
    LN_BIT_H,
    LN_BIT_L
  } line_phase_e;

  typedef struct packed {
    logic                        level;
    logic                        busy;
    logic [vcpt_pkg::STAT_W-1:0] status;
    logic                        done;
  } line_result_t;

  logic [19:0]  short_len;
  logic [19:0]  long_len;
  logic [19:0]  start_len;
  logic [19:0]  rst_hi_len;
  logic [19:0]  rst_lo_len;
  logic         invert;
  logic [0:119] frame;
  int           nbits;
  logic         extra_one;
  int           bit_idx;
  line_phase_e  phase;
  logic [19:0]  tick_cnt;
  line_result_t line_results_q[$];
  line_result_t want;
  line_result_t got;

  // bit positions count from the msb of byte 0, value goes in lsb first
  function automatic logic [0:119] put_bits(input logic [0:119] f, input int pos,
                                            input logic [6:0] v, input int len);
    logic [0:119] r;
    r = f;
    for (int k = 0; k < len; k++) r[pos+k] = v[k];
    return r;
  endfunction

  function automatic logic [0:119] zone_bits(input logic [5:0] zone, input logic [7:0] mins);
    logic [0:119] f;
    logic [6:0]   z7;
    logic [6:0]   lo;
    logic [6:0]   hi;
    logic [6:0]   zm1;
    z7  = {1'b0, zone};
    lo  = {3'b000, mins[3:0]};
    hi  = {3'b000, mins[7:4]};
    zm1 = z7 - 7'd1;
    f = ZONE_PATTERN;
    f = put_bits(f, 9, (zone > ZONE_GROUP_1) ? 7'd1 : 7'd2, 2);
    f = put_bits(f, 23, z7 + ZONE_OFFSET_1, 7);
    f = put_bits(f, 36, z7 + ZONE_OFFSET_1, 7);
    f = put_bits(f, 49, z7 + ZONE_OFFSET_2, 7);
    f = put_bits(f, 62, z7 + ZONE_OFFSET_2, 7);
    f = put_bits(f, 75, z7 + ZONE_OFFSET_3, 7);
    f = put_bits(f, 88, z7 + ZONE_OFFSET_3, 7);
    f = put_bits(f, 31, lo, 4);
    f = put_bits(f, 44, hi, 4);
    f = put_bits(f, 57, lo, 4);
    f = put_bits(f, 70, hi, 4);
    f = put_bits(f, 83, lo, 4);
    f = put_bits(f, 96, hi, 4);
    f = put_bits(f, 109, {3'b000, zm1[3:0]}, 4);
    return f;
  endfunction

  function automatic logic [19:0] at_least_1(input logic [19:0] v);
    return (v == 20'd0) ? 20'd1 : v;
  endfunction

  function automatic logic frame_bit();
    if (bit_idx < nbits) return frame[bit_idx];
    return extra_one && (bit_idx == nbits);
  endfunction

  function automatic logic [19:0] phase_ticks();
    case (phase)
      LN_RST_H:   return at_least_1(rst_hi_len);
      LN_RST_L:   return at_least_1(rst_lo_len);
      LN_START_H: return at_least_1(start_len);
      LN_START_L: return at_least_1(short_len);
      LN_BIT_H:   return at_least_1(frame_bit() ? long_len : short_len);
      LN_BIT_L:   return at_least_1(frame_bit() ? short_len : long_len);
      default:    return 20'd1;
    endcase
  endfunction

  function automatic void start_frame(input logic [0:119] f, input int bits, input logic ext);
    frame     = f;
    nbits     = bits;
    extra_one = ext;
    bit_idx   = 0;
    phase     = LN_RST_H;
    tick_cnt  = '0;
  endfunction

  // one beat in, one result out; updates the line state
  function automatic line_result_t step_line(input logic [1:0] kind, input logic [5:0] zone,
                                             input logic [7:0] mins, input logic [2:0] prog);
    line_result_t r;
    logic [0:119] f;
    logic [2:0]   pm1;
    r = '0;
    r.status = vcpt_pkg::ST_OK;
    if (kind == vcpt_pkg::KIND_ZONE || kind == vcpt_pkg::KIND_PROG) begin
      if (phase != LN_IDLE) begin
        r.status = vcpt_pkg::ST_BUSY;
      end else if (kind == vcpt_pkg::KIND_ZONE) begin
        if (zone < 1 || zone > ZONE_LAST) begin
          r.status = vcpt_pkg::ST_BAD_ZONE;
        end else if (mins > MINUTES_MAX) begin
          r.status = vcpt_pkg::ST_BAD_TIME;
        end else begin
          start_frame(zone_bits(zone, mins), 120, 1'b1);
        end
      end else if (prog < 1 || prog > PROG_LAST) begin
        r.status = vcpt_pkg::ST_BAD_PROG;
      end else begin
        pm1 = prog - 3'd1;
        f = '0;
        f[0:55] = PROG_PATTERN;
        f = put_bits(f, 31, {5'b00000, pm1[1:0]}, 2);
        start_frame(f, 56, 1'b0);
      end
    end else if (kind == vcpt_pkg::KIND_TICK && phase != LN_IDLE) begin
      tick_cnt = tick_cnt + 20'd1;
      if (tick_cnt >= phase_ticks()) begin
        tick_cnt = '0;
        case (phase)
          LN_RST_H:   phase = LN_RST_L;
          LN_RST_L:   phase = LN_START_H;
          LN_START_H: phase = LN_START_L;
          LN_START_L: phase = LN_BIT_H;
          LN_BIT_H:   phase = LN_BIT_L;
          LN_BIT_L: begin
            if (bit_idx >= nbits + int'(extra_one)) begin
              phase   = LN_IDLE;
              bit_idx = 0;
              r.done  = 1'b1;
            end else begin
              bit_idx = bit_idx + 1;
              phase   = LN_BIT_H;
            end
          end
          default:    phase = LN_IDLE;
        endcase
      end
    end
    r.level = (phase == LN_RST_H || phase == LN_START_H || phase == LN_BIT_H) ^ invert;
    r.busy  = (phase != LN_IDLE);
    return r;
  endfunction

  task automatic check_field(input string what, input int exp, input int act);
    if (exp != act) begin
      $display("%0t: %s expected %0d got %0d", $time, what, exp, act);
      fail_count_o = fail_count_o + 1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_len  = {4'd0, vcpt_pkg::SHORT_RST};
      long_len   = {4'd0, vcpt_pkg::LONG_RST};
      start_len  = {4'd0, vcpt_pkg::START_RST};
      rst_hi_len = vcpt_pkg::RST_HI_RST;
      rst_lo_len = vcpt_pkg::RST_LO_RST;
      invert     = 1'b0;
      frame      = '0;
      nbits      = 0;
      extra_one  = 1'b0;
      bit_idx    = 0;
      phase      = LN_IDLE;
      tick_cnt   = '0;
      line_results_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          vcpt_pkg::REG_SHORT:  short_len  = {4'd0, cfg_wdata_i[15:0]};
          vcpt_pkg::REG_LONG:   long_len   = {4'd0, cfg_wdata_i[15:0]};
          vcpt_pkg::REG_START:  start_len  = {4'd0, cfg_wdata_i[15:0]};
          vcpt_pkg::REG_RST_HI: rst_hi_len = cfg_wdata_i;
          vcpt_pkg::REG_RST_LO: rst_lo_len = cfg_wdata_i;
          vcpt_pkg::REG_INVERT: invert     = cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        want = step_line(s_axis_tuser_i, s_axis_tdata_i[5:0], s_axis_tdata_i[13:6],
                         s_axis_tdata_i[16:14]);
        line_results_q.push_back(want);
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.level  = m_axis_tdata_i[0];
        got.busy   = m_axis_tdata_i[1];
        got.status = m_axis_tdata_i[4:2];
        got.done   = m_axis_tlast_i;
        if (line_results_q.size() == 0) begin
          $display("%0t: result beat with none expected, got level %0d busy %0d",
                   $time, got.level, got.busy);
          $display("%0t: status %0d done %0d", $time, got.status, got.done);
          fail_count_o = fail_count_o + 1;
        end else begin
          want = line_results_q.pop_front();
          check_field("line_level", int'(want.level), int'(got.level));
          check_field("busy", int'(want.busy), int'(got.busy));
          check_field("status", int'(want.status), int'(got.status));
          check_field("frame_done", int'(want.done), int'(got.done));
        end
      end
      pending_o = line_results_q.size();
    end
  end

endmodule

### test/valve_command_pulse_transmitter_tb.sv
// valve_command_pulse_transmitter_tb: drives commands, ticks and register
// writes into the transmitter; depends on vcpt_pkg, the block and the monitor

module valve_command_pulse_transmitter_tb;

  localparam logic [vcpt_pkg::IN_TUSER_W-1:0] KIND_SPARE  = 2'd3;
  localparam logic [vcpt_pkg::CFG_ADDR_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [vcpt_pkg::CFG_ADDR_W-1:0] REG_SPARE_B = 3'd7;
  localparam int                              TAIL_BEATS  = 24;

  logic                             clk       = 1'b0;
  logic                             rst_n     = 1'b0;
  logic                             s_tvalid  = 1'b0;
  logic                             s_tready;
  logic [vcpt_pkg::IN_TDATA_W-1:0]  s_tdata   = '0;
  logic [vcpt_pkg::IN_TUSER_W-1:0]  s_tuser   = '0;
  logic                             m_tvalid;
  logic                             m_tready  = 1'b0;
  logic [vcpt_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic                             m_tlast;
  logic                             cfg_we    = 1'b0;
  logic [vcpt_pkg::CFG_ADDR_W-1:0]  cfg_addr  = '0;
  logic [vcpt_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;
  int                               fail_count;
  int                               pending;

  int          burst_left = 0;
  bit          steady     = 1'b0;
  logic [9:0]  rx_cycle   = '0;
  logic [19:0] t_short, t_long, t_start, t_rst_hi, t_rst_lo;

  valve_command_pulse_transmitter dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata)
  );

  valve_command_pulse_transmitter_monitor line_monitor (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .m_axis_tlast_i  (m_tlast),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // receiver cycles through free-running, random and fixed stall patterns
  always @(negedge clk) begin
    rx_cycle <= rx_cycle + 10'd1;
    case (rx_cycle[9:8])
      2'd0:    m_tready <= 1'b1;
      2'd1:    m_tready <= ($urandom_range(0, 3) != 0);
      2'd2:    m_tready <= (rx_cycle[3:0] < 4'd11);
      default: m_tready <= ($urandom_range(0, 1) != 0);
    endcase
  end

  initial begin
    #8000000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic int at_least_1(input logic [19:0] v);
    return (v == 20'd0) ? 1 : int'(v);
  endfunction

  // entered and left at a falling edge; the beat is held until taken
  task automatic send_beat(input logic [1:0] kind, input logic [5:0] zone,
                           input logic [7:0] mins, input logic [2:0] prog);
    int gap;
    if (burst_left == 0) begin
      gap = steady ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 48);
    end
    burst_left = burst_left - 1;
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {7'd0, prog, mins, zone};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_kind(input logic [1:0] kind);
    send_beat(kind, 6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)),
              3'($urandom_range(0, 7)));
  endtask

  task automatic quiesce();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [vcpt_pkg::CFG_ADDR_W-1:0] idx,
                           input logic [vcpt_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
  endtask

  task automatic set_timing(input logic [15:0] sh, input logic [15:0] lg, input logic [15:0] st,
                            input logic [19:0] rh, input logic [19:0] rl, input logic inv);
    quiesce();
    t_short  = {4'd0, sh};
    t_long   = {4'd0, lg};
    t_start  = {4'd0, st};
    t_rst_hi = rh;
    t_rst_lo = rl;
    write_reg(vcpt_pkg::REG_SHORT, {4'd0, sh});
    write_reg(vcpt_pkg::REG_LONG, {4'd0, lg});
    write_reg(vcpt_pkg::REG_START, {4'd0, st});
    write_reg(vcpt_pkg::REG_RST_HI, rh);
    write_reg(vcpt_pkg::REG_RST_LO, rl);
    write_reg(vcpt_pkg::REG_INVERT, {19'd0, inv});
    // unmapped indexes must be ignored
    write_reg(REG_SPARE_A, 20'($urandom_range(0, 20'hfffff)));
    write_reg(REG_SPARE_B, 20'($urandom_range(0, 20'hfffff)));
    cfg_we <= 1'b0;
  endtask

  // stray commands land only while the frame is still on the line
  task automatic send_ticks(input int n);
    for (int t = 0; t < n; t++) begin
      if ($urandom_range(0, 79) == 0) begin
        send_kind(2'($urandom_range(int'(vcpt_pkg::KIND_ZONE), int'(KIND_SPARE))));
      end
      send_kind(vcpt_pkg::KIND_TICK);
    end
  endtask

  // every bit costs long + short ticks whatever its value, so the frame length is exact
  task automatic run_frame(input bit is_zone);
    int ticks;
    ticks = at_least_1(t_rst_hi) + at_least_1(t_rst_lo) + at_least_1(t_start) +
            at_least_1(t_short) +
            (is_zone ? 122 : 57) * (at_least_1(t_long) + at_least_1(t_short));
    send_ticks(ticks);
  endtask

  initial begin
    logic [5:0] zone;
    logic [7:0] mins;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // idle behavior at reset timing, then a rejected command
    send_kind(vcpt_pkg::KIND_TICK);
    send_kind(KIND_SPARE);
    send_beat(vcpt_pkg::KIND_ZONE, 6'd0, 8'd10, 3'd0);

    // long differs from short so every frame bit shows on the line
    set_timing(16'd1, 16'd2, 16'd1, 20'd1, 20'd1, 1'b0);
    send_beat(vcpt_pkg::KIND_ZONE, 6'd49, 8'd0, 3'd0);
    send_beat(vcpt_pkg::KIND_ZONE, 6'd63, 8'd255, 3'd7);
    send_beat(vcpt_pkg::KIND_ZONE, 6'd1, 8'd241, 3'd0);
    send_beat(vcpt_pkg::KIND_ZONE, 6'd48, 8'd255, 3'd0);
    send_beat(vcpt_pkg::KIND_PROG, 6'd0, 8'd0, 3'd0);
    send_beat(vcpt_pkg::KIND_PROG, 6'd0, 8'd0, 3'd5);
    send_beat(vcpt_pkg::KIND_PROG, 6'd63, 8'd255, 3'd7);
    send_beat(vcpt_pkg::KIND_ZONE, 6'd48, 8'd240, 3'd0);
    // commands while the frame is going out
    send_beat(vcpt_pkg::KIND_ZONE, 6'd5, 8'd5, 3'd0);
    send_beat(vcpt_pkg::KIND_PROG, 6'd0, 8'd0, 3'd1);
    send_beat(vcpt_pkg::KIND_ZONE, 6'd0, 8'd0, 3'd0);
    send_kind(KIND_SPARE);
    run_frame(1'b1);

    // reset impulse longer than 16 bits holds the line past a few ticks, then a
    // short setting ends it; zero lengths act as one tick
    set_timing(16'd0, 16'd2, 16'd0, 20'h10005, 20'd0, 1'b1);
    send_beat(vcpt_pkg::KIND_PROG, 6'd63, 8'd255, 3'($urandom_range(1, 4)));
    send_ticks(8);
    set_timing(16'd0, 16'd2, 16'd0, 20'd0, 20'd0, 1'b1);
    run_frame(1'b0);

    // group field below zone 13; the head of the frame shows its bits, the rest
    // goes out with equal pulse lengths
    set_timing(16'd0, 16'd2, 16'd0, 20'd0, 20'd0, 1'b0);
    steady = 1'b1;
    mins = 8'($urandom_range(0, 240));
    send_beat(vcpt_pkg::KIND_ZONE, 6'd12, mins, 3'($urandom_range(0, 7)));
    send_ticks(4 + 16 * 3);
    set_timing(16'd0, 16'd0, 16'd0, 20'd0, 20'd0, 1'b0);
    send_ticks(106 * 2);

    // rejected commands, spare kinds and idle ticks
    repeat (TAIL_BEATS) begin
      steady = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 4))
        0: begin
          zone = $urandom_range(0, 1) ? 6'd0 : 6'($urandom_range(49, 63));
          send_beat(vcpt_pkg::KIND_ZONE, zone, 8'($urandom_range(0, 255)),
                    3'($urandom_range(0, 7)));
        end
        1: send_beat(vcpt_pkg::KIND_ZONE, 6'($urandom_range(1, 48)),
                     8'($urandom_range(241, 255)), 3'($urandom_range(0, 7)));
        2: send_beat(vcpt_pkg::KIND_PROG, 6'($urandom_range(0, 63)),
                     8'($urandom_range(0, 255)),
                     $urandom_range(0, 1) ? 3'd0 : 3'($urandom_range(5, 7)));
        3: send_kind(KIND_SPARE);
        default: repeat ($urandom_range(1, 3)) send_kind(vcpt_pkg::KIND_TICK);
      endcase
      if ($urandom_range(0, 7) == 0) quiesce();
    end

    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
